@@ rtl/crc_pkg.sv @@
// ----------------------------------------------------------------------------
// Color region uniform classifier: shared package
// Widths, register indexes, color and percentage thresholds, helper functions.
// ----------------------------------------------------------------------------
package crc_pkg;

	localparam int FRAME_DIM = 4096;
	localparam longint unsigned COUNT_MAX = longint'(FRAME_DIM) * longint'(FRAME_DIM);
	localparam int CNT_W = $clog2(COUNT_MAX + 1);
	localparam int TOT_W = CNT_W + 2;
	localparam int PROD_W = TOT_W + 7;

	localparam int CHAN_W = 8;
	localparam int COORD_W = 12;
	localparam int SPAN_W = 13;
	localparam int POS_W = 14;
	localparam int CONF_W = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 13;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		count_t bright;
		count_t dim;
		count_t other;
	} counts_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BODY_X      = 4'd0,
		REG_BODY_Y      = 4'd1,
		REG_BODY_WIDTH  = 4'd2,
		REG_BODY_HEIGHT = 4'd3
	} cfg_reg_t;

	localparam logic [CHAN_W-1:0] BRIGHT_B_MIN = 8'd225;
	localparam logic [CHAN_W-1:0] BRIGHT_GR_MIN = 8'd220;
	localparam logic [CHAN_W-1:0] DIM_B_LO = 8'd170;
	localparam logic [CHAN_W-1:0] DIM_B_HI = 8'd225;
	localparam logic [CHAN_W-1:0] DIM_GR_LO = 8'd160;
	localparam logic [CHAN_W-1:0] DIM_GR_HI = 8'd220;

	localparam logic [PROD_W-1:0] PCT_FULL = PROD_W'(100);
	localparam logic [PROD_W-1:0] PCT_PRIM_HIGH = PROD_W'(90);
	localparam logic [PROD_W-1:0] PCT_BRIGHT_HIGH = PROD_W'(75);
	localparam logic [PROD_W-1:0] PCT_PRIM_MID = PROD_W'(75);
	localparam logic [PROD_W-1:0] PCT_BRIGHT_MID = PROD_W'(60);
	localparam logic [PROD_W-1:0] PCT_PRIM_LOW = PROD_W'(55);
	localparam logic [PROD_W-1:0] PCT_BRIGHT_LOW = PROD_W'(45);

	localparam logic [CONF_W-1:0] CONF_HIGH = 7'd80;
	localparam logic [CONF_W-1:0] CONF_MID = 7'd65;
	localparam logic [CONF_W-1:0] CONF_LOW = 7'd50;
	localparam logic [CONF_W-1:0] CONF_NONE = 7'd0;

	// floor(x/3) by reciprocal, exact for x below 2**16
	function automatic logic [POS_W-1:0] div3(input logic [POS_W-1:0] x);
		logic [30:0] p;
		p = 31'(x) * 31'(17'd43691);
		return p[30:17];
	endfunction

	function automatic count_t sat_inc(input count_t c);
		return (c < CNT_W'(COUNT_MAX)) ? c + 1'b1 : c;
	endfunction

endpackage

@@ rtl/crc_verdict.sv @@
// ----------------------------------------------------------------------------
// Frame verdict pipeline
// Turns final class counts into is_doctor and confidence over three stages
// and an output register, with per-stage flow control.
// ----------------------------------------------------------------------------
module crc_verdict (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  crc_pkg::counts_t            counts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_doctor,
	output logic [crc_pkg::CONF_W-1:0]  confidence
);

	logic v_s3, v_s4, v_s5;
	logic rdy_out, rdy_s5, rdy_s4;

	crc_pkg::counts_t cnt_s3;

	logic [crc_pkg::TOT_W-1:0] total_s4, primary_s4;
	crc_pkg::count_t bright_s4;

	logic [crc_pkg::PROD_W-1:0] b100_s5, p100_s5;
	logic [crc_pkg::PROD_W-1:0] t45_s5, t55_s5, t60_s5, t75_s5, t90_s5;
	logic nz_s5;

	logic doc_d;
	logic [crc_pkg::CONF_W-1:0] conf_d;
	logic out_valid_q, is_doctor_q;
	logic [crc_pkg::CONF_W-1:0] confidence_q;

	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s5 = !v_s5 || rdy_out;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign in_ready = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) cnt_s3 <= counts;
		if (rdy_s4) begin
			total_s4 <= crc_pkg::TOT_W'(cnt_s3.bright) + crc_pkg::TOT_W'(cnt_s3.dim)
				+ crc_pkg::TOT_W'(cnt_s3.other);
			primary_s4 <= crc_pkg::TOT_W'(cnt_s3.bright) + crc_pkg::TOT_W'(cnt_s3.dim);
			bright_s4 <= cnt_s3.bright;
		end
		if (rdy_s5) begin
			b100_s5 <= crc_pkg::PROD_W'(bright_s4) * crc_pkg::PCT_FULL;
			p100_s5 <= crc_pkg::PROD_W'(primary_s4) * crc_pkg::PCT_FULL;
			t45_s5 <= crc_pkg::PROD_W'(total_s4) * crc_pkg::PCT_BRIGHT_LOW;
			t55_s5 <= crc_pkg::PROD_W'(total_s4) * crc_pkg::PCT_PRIM_LOW;
			t60_s5 <= crc_pkg::PROD_W'(total_s4) * crc_pkg::PCT_BRIGHT_MID;
			t75_s5 <= crc_pkg::PROD_W'(total_s4) * crc_pkg::PCT_BRIGHT_HIGH;
			t90_s5 <= crc_pkg::PROD_W'(total_s4) * crc_pkg::PCT_PRIM_HIGH;
			nz_s5 <= (total_s4 != '0);
		end
		if (rdy_out) begin
			is_doctor_q <= doc_d;
			confidence_q <= conf_d;
		end
	end

	always_comb begin
		doc_d = 1'b0;
		conf_d = crc_pkg::CONF_NONE;
		if (nz_s5 && (b100_s5 >= t45_s5)) begin
			if ((p100_s5 >= t90_s5) && (b100_s5 >= t75_s5)) begin
				doc_d = 1'b1;
				conf_d = crc_pkg::CONF_HIGH;
			end else if ((p100_s5 >= t75_s5) && (b100_s5 >= t60_s5)) begin
				doc_d = 1'b1;
				conf_d = crc_pkg::CONF_MID;
			end else if (p100_s5 >= t55_s5) begin
				doc_d = 1'b1;
				conf_d = crc_pkg::CONF_LOW;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign is_doctor = is_doctor_q;
	assign confidence = confidence_q;

	a_no_doc_zero_conf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_doctor_q) |-> (confidence_q == crc_pkg::CONF_NONE))
		else $error("verdict without match carries nonzero confidence");

	a_doc_conf_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_doctor_q) |-> (confidence_q == crc_pkg::CONF_HIGH ||
		confidence_q == crc_pkg::CONF_MID || confidence_q == crc_pkg::CONF_LOW))
		else $error("matching verdict has unexpected confidence");

	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s5))
		else $error("output word appeared without a stage 5 word");

endmodule

@@ rtl/color_region_uniform_classifier.sv @@
// ----------------------------------------------------------------------------
// Color region uniform classifier
// Counts bright white, dim white and other pixels in the body rectangle
// outside its mid-chest strip and gives a verdict at each frame end.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: in_valid/in_stall with blue, green, red, col, row and
//   frame_end, one pixel per cycle unless stalled. Only a frame_end word makes
//   a result word on the out_valid/out_stall channel (is_doctor, confidence).
//   Config channel: cfg_valid/cfg_ready, always ready, cfg_index selects
//   body_x, body_y, body_width, body_height; unknown indexes are dropped.
//   Write config between frames; derived bounds are registered from it.
//   A frame_end word passes the input, class, counts, sums and products
//   registers in that order; the compare feeds the output register.
//   Throughput: one pixel per cycle unless stalled (single class/count stage).
//   While the receiver stalls, the result holds in the output register and
//   pixels keep flowing into the counters; in_stall rises only once three
//   further verdict words fill the pipeline behind it.
//   Reset clears the config registers, the counters and all valid flags.
// ----------------------------------------------------------------------------
module color_region_uniform_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [crc_pkg::CHAN_W-1:0]      blue,
	input  logic [crc_pkg::CHAN_W-1:0]      green,
	input  logic [crc_pkg::CHAN_W-1:0]      red,
	input  logic [crc_pkg::COORD_W-1:0]     col,
	input  logic [crc_pkg::COORD_W-1:0]     row,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_doctor,
	output logic [crc_pkg::CONF_W-1:0]      confidence
);

	logic [crc_pkg::COORD_W-1:0] body_x_q, body_y_q;
	logic [crc_pkg::SPAN_W-1:0] body_width_q, body_height_q;

	logic [crc_pkg::POS_W-1:0] third_d, strip_h_d;
	logic [crc_pkg::POS_W-1:0] x_end_q, y_end_q, sx_lo_q, sx_hi_q, sy_end_q;

	logic v_s1, v_s2, rdy_s1, rdy_s2;
	logic [crc_pkg::CHAN_W-1:0] blue_s1, green_s1, red_s1;
	logic [crc_pkg::COORD_W-1:0] col_s1, row_s1;
	logic fe_s1, fe_s2;

	logic [crc_pkg::POS_W-1:0] c_ext, r_ext;
	logic in_body, in_strip, counted, is_bright, is_dim;
	logic [2:0] bump_d, bump_s2;

	crc_pkg::counts_t cnt_q, cnt_next;
	logic vd_ready, vd_valid, s2_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_x_q <= '0;
			body_y_q <= '0;
			body_width_q <= '0;
			body_height_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				crc_pkg::REG_BODY_X: body_x_q <= cfg_data[crc_pkg::COORD_W-1:0];
				crc_pkg::REG_BODY_Y: body_y_q <= cfg_data[crc_pkg::COORD_W-1:0];
				crc_pkg::REG_BODY_WIDTH: body_width_q <= cfg_data;
				crc_pkg::REG_BODY_HEIGHT: body_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign third_d = crc_pkg::div3(crc_pkg::POS_W'(body_width_q));
	assign strip_h_d = crc_pkg::div3({body_height_q, 1'b0});

	always_ff @(posedge clk) begin
		x_end_q <= crc_pkg::POS_W'(body_x_q) + crc_pkg::POS_W'(body_width_q);
		y_end_q <= crc_pkg::POS_W'(body_y_q) + crc_pkg::POS_W'(body_height_q);
		sx_lo_q <= crc_pkg::POS_W'(body_x_q) + third_d;
		sx_hi_q <= crc_pkg::POS_W'(body_x_q) + {third_d[crc_pkg::POS_W-2:0], 1'b0};
		sy_end_q <= crc_pkg::POS_W'(body_y_q) + strip_h_d;
	end

	assign rdy_s2 = !v_s2 || !fe_s2 || vd_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			blue_s1 <= blue;
			green_s1 <= green;
			red_s1 <= red;
			col_s1 <= col;
			row_s1 <= row;
			fe_s1 <= frame_end;
		end
		if (rdy_s2) begin
			bump_s2 <= bump_d;
			fe_s2 <= fe_s1;
		end
	end

	always_comb begin
		c_ext = crc_pkg::POS_W'(col_s1);
		r_ext = crc_pkg::POS_W'(row_s1);
		in_body = (col_s1 >= body_x_q) && (c_ext < x_end_q)
			&& (row_s1 >= body_y_q) && (r_ext < y_end_q);
		in_strip = (c_ext >= sx_lo_q) && (c_ext < sx_hi_q)
			&& (row_s1 >= body_y_q) && (r_ext < sy_end_q);
		counted = in_body && !in_strip;
		is_bright = (blue_s1 > crc_pkg::BRIGHT_B_MIN) && (green_s1 > crc_pkg::BRIGHT_GR_MIN)
			&& (red_s1 > crc_pkg::BRIGHT_GR_MIN);
		is_dim = (blue_s1 inside {[crc_pkg::DIM_B_LO:crc_pkg::DIM_B_HI]})
			&& (green_s1 inside {[crc_pkg::DIM_GR_LO:crc_pkg::DIM_GR_HI]})
			&& (red_s1 inside {[crc_pkg::DIM_GR_LO:crc_pkg::DIM_GR_HI]});
		bump_d[2] = counted && is_bright;
		bump_d[1] = counted && !is_bright && is_dim;
		bump_d[0] = counted && !is_bright && !is_dim;
	end

	always_comb begin
		cnt_next = cnt_q;
		if (bump_s2[2]) cnt_next.bright = crc_pkg::sat_inc(cnt_q.bright);
		if (bump_s2[1]) cnt_next.dim = crc_pkg::sat_inc(cnt_q.dim);
		if (bump_s2[0]) cnt_next.other = crc_pkg::sat_inc(cnt_q.other);
	end

	assign s2_take = v_s2 && rdy_s2;
	assign vd_valid = v_s2 && fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s2_take) begin
			cnt_q <= fe_s2 ? '0 : cnt_next;
		end
	end

	crc_verdict u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vd_valid),
		.in_ready   (vd_ready),
		.counts     (cnt_next),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_doctor  (is_doctor),
		.confidence (confidence)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q.bright <= crc_pkg::CNT_W'(crc_pkg::COUNT_MAX))
		&& (cnt_q.dim <= crc_pkg::CNT_W'(crc_pkg::COUNT_MAX))
		&& (cnt_q.other <= crc_pkg::CNT_W'(crc_pkg::COUNT_MAX)))
		else $error("class counter above saturation limit");

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_take && fe_s2) |=> (cnt_q == '0))
		else $error("counters not cleared after frame end");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_one_class: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(bump_s2))
		else $error("pixel counted in more than one class");

endmodule
